>>> rtl/vae_pkg.sv
// vae_pkg: shared widths, constants, arctangent table and payload types
// for the vector to azimuth/elevation pipeline; no dependencies
`timescale 1ns / 1ps

package vae_pkg;

  localparam int COORD_W           = 24;
  localparam int DIFF_W            = COORD_W + 1;
  localparam int SQR_W             = 2 * DIFF_W;
  localparam int FRAC_PAD          = 14;
  localparam int SQ_IN_W           = SQR_W + FRAC_PAD;
  localparam int SQ_OUT_W          = SQ_IN_W / 2;
  localparam int SQ_STAGES         = SQ_OUT_W;
  localparam int SQ_REM_W          = SQ_OUT_W + 2;
  localparam int CORDIC_W          = 52;
  localparam int ANG_W             = 27;
  localparam int RND_SHIFT         = 8;
  localparam int RND_W             = ANG_W - RND_SHIFT;
  localparam int AZ_W              = 17;
  localparam int EL_W              = 16;
  localparam int VEC_SHIFT         = 24;
  localparam int EL_X_SHIFT        = 17;
  localparam int ATAN_LEN          = 24;
  localparam int CORDIC_STAGES_DEF = 16;

  localparam logic signed [ANG_W-1:0] DEG180_Q16 = 27'sd11796480;
  localparam logic signed [ANG_W-1:0] ROUND_HALF = 27'sd128;
  localparam logic signed [RND_W-1:0] AZ_LIMIT   = 19'sd46080;
  localparam logic signed [RND_W-1:0] AZ_SPAN    = 19'sd92160;
  localparam logic signed [RND_W-1:0] EL_LIMIT   = 19'sd22784;

  // atan(2^-i) in degrees * 65536
  localparam logic signed [ANG_W-1:0] ATAN_TAB [ATAN_LEN] = '{
    27'sd2949120, 27'sd1740967, 27'sd919879, 27'sd466945,
    27'sd234379,  27'sd117304,  27'sd58666,  27'sd29335,
    27'sd14668,   27'sd7334,    27'sd3667,   27'sd1833,
    27'sd917,     27'sd458,     27'sd229,    27'sd115,
    27'sd57,      27'sd29,      27'sd14,     27'sd7,
    27'sd4,       27'sd2,       27'sd1,      27'sd0
  };

  typedef struct packed {
    logic signed [COORD_W-1:0] source_x;
    logic signed [COORD_W-1:0] source_y;
    logic signed [COORD_W-1:0] source_z;
    logic signed [COORD_W-1:0] target_x;
    logic signed [COORD_W-1:0] target_y;
    logic signed [COORD_W-1:0] target_z;
  } in_item_t;

  typedef struct packed {
    logic signed [AZ_W-1:0] azimuth;
    logic signed [EL_W-1:0] elevation;
  } out_result_t;

endpackage

>>> rtl/vae_sqrt.sv
// vae_sqrt: pipelined integer square root, one result bit per stage
// with a sideband that travels alongside; depends on vae_pkg
`timescale 1ns / 1ps

module vae_sqrt import vae_pkg::*; #(
  parameter int SIDE_W = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [SQ_IN_W-1:0]  in_n,
  input  logic [SIDE_W-1:0]   in_side,
  output logic                out_valid,
  output logic [SQ_OUT_W-1:0] out_root,
  output logic [SIDE_W-1:0]   out_side
);

  logic                v_r    [SQ_STAGES];
  logic [SQ_OUT_W-1:0] root_r [SQ_STAGES];
  logic [SIDE_W-1:0]   side_r [SQ_STAGES];
  logic [SQ_REM_W-1:0] rem_r  [SQ_STAGES-1];
  logic [SQ_IN_W-1:0]  n_r    [SQ_STAGES-1];

  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_stage
    logic                v_prev;
    logic [SQ_OUT_W-1:0] root_prev;
    logic [SIDE_W-1:0]   side_prev;
    logic [SQ_REM_W-1:0] rem_prev;
    logic [SQ_IN_W-1:0]  n_prev;
    logic [SQ_REM_W+1:0] acc;
    logic [SQ_REM_W+1:0] trial;
    logic [SQ_REM_W+1:0] diff;
    logic                take;
    logic [SQ_REM_W-1:0] rem_nxt;
    logic [SQ_OUT_W-1:0] root_nxt;

    if (k == 0) begin : g_first
      assign v_prev    = in_valid;
      assign root_prev = '0;
      assign side_prev = in_side;
      assign rem_prev  = '0;
      assign n_prev    = in_n;
    end else begin : g_next
      assign v_prev    = v_r[k-1];
      assign root_prev = root_r[k-1];
      assign side_prev = side_r[k-1];
      assign rem_prev  = rem_r[k-1];
      assign n_prev    = n_r[k-1];
    end

    assign acc   = {rem_prev, n_prev[SQ_IN_W-1-2*k -: 2]};
    assign trial = {2'b00, root_prev, 2'b01};
    assign diff  = acc - trial;
    assign take  = (acc >= trial);

    always_comb begin
      if (take) begin
        rem_nxt  = diff[SQ_REM_W-1:0];
        root_nxt = {root_prev[SQ_OUT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = acc[SQ_REM_W-1:0];
        root_nxt = {root_prev[SQ_OUT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else begin
        v_r[k] <= v_prev;
      end
    end

    always_ff @(posedge clk) begin
      root_r[k] <= root_nxt;
      side_r[k] <= side_prev;
    end

    if (k < SQ_STAGES - 1) begin : g_carry
      always_ff @(posedge clk) begin
        rem_r[k] <= rem_nxt;
        n_r[k]   <= n_prev;
      end
    end
  end

  assign out_valid = v_r[SQ_STAGES-1];
  assign out_root  = root_r[SQ_STAGES-1];
  assign out_side  = side_r[SQ_STAGES-1];

endmodule

>>> rtl/vae_cordic.sv
// vae_cordic: unrolled vectoring cordic, one micro-rotation per register
// stage, accumulating the angle in degrees * 65536; depends on vae_pkg
`timescale 1ns / 1ps

module vae_cordic import vae_pkg::*; #(
  parameter int STAGES = CORDIC_STAGES_DEF,
  parameter int SIDE_W = 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic signed [CORDIC_W-1:0] in_x,
  input  logic signed [CORDIC_W-1:0] in_y,
  input  logic signed [ANG_W-1:0]    in_z,
  input  logic [SIDE_W-1:0]          in_side,
  output logic                       out_valid,
  output logic signed [ANG_W-1:0]    out_z,
  output logic [SIDE_W-1:0]          out_side
);

  logic                       v_r    [STAGES];
  logic signed [ANG_W-1:0]    z_r    [STAGES];
  logic [SIDE_W-1:0]          side_r [STAGES];
  logic signed [CORDIC_W-1:0] x_r    [STAGES-1];
  logic signed [CORDIC_W-1:0] y_r    [STAGES-1];

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic                       v_prev;
    logic signed [CORDIC_W-1:0] x_prev;
    logic signed [CORDIC_W-1:0] y_prev;
    logic signed [ANG_W-1:0]    z_prev;
    logic [SIDE_W-1:0]          side_prev;
    logic signed [CORDIC_W-1:0] xs;
    logic signed [CORDIC_W-1:0] ys;
    logic signed [ANG_W-1:0]    step;
    logic signed [CORDIC_W-1:0] x_nxt;
    logic signed [CORDIC_W-1:0] y_nxt;
    logic signed [ANG_W-1:0]    z_nxt;

    if (i == 0) begin : g_first
      assign v_prev    = in_valid;
      assign x_prev    = in_x;
      assign y_prev    = in_y;
      assign z_prev    = in_z;
      assign side_prev = in_side;
    end else begin : g_next
      assign v_prev    = v_r[i-1];
      assign x_prev    = x_r[i-1];
      assign y_prev    = y_r[i-1];
      assign z_prev    = z_r[i-1];
      assign side_prev = side_r[i-1];
    end

    if (i < ATAN_LEN) begin : g_tab
      assign step = ATAN_TAB[i];
    end else begin : g_none
      assign step = '0;
    end

    assign xs = x_prev >>> i;
    assign ys = y_prev >>> i;

    always_comb begin
      if (!y_prev[CORDIC_W-1]) begin
        x_nxt = x_prev + ys;
        y_nxt = y_prev - xs;
        z_nxt = z_prev + step;
      end else begin
        x_nxt = x_prev - ys;
        y_nxt = y_prev + xs;
        z_nxt = z_prev - step;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else begin
        v_r[i] <= v_prev;
      end
    end

    always_ff @(posedge clk) begin
      z_r[i]    <= z_nxt;
      side_r[i] <= side_prev;
    end

    if (i < STAGES - 1) begin : g_carry
      always_ff @(posedge clk) begin
        x_r[i] <= x_nxt;
        y_r[i] <= y_nxt;
      end
    end
  end

  assign out_valid = v_r[STAGES-1];
  assign out_z     = z_r[STAGES-1];
  assign out_side  = side_r[STAGES-1];

endmodule

>>> rtl/vector_to_azimuth_elevation_unit.sv
// vector_to_azimuth_elevation_unit: top level, difference vector, squares,
// square root and two cordic pipelines; depends on vae_pkg, vae_sqrt, vae_cordic
`timescale 1ns / 1ps

// Takes a source and a target point (signed, 4 fraction bits) and returns the
// azimuth (wrapped to +-180 degrees) and elevation (saturated at +-89 degrees)
// of target minus source, both in degrees with 8 fraction bits. A new
// transaction can be started every clock cycle; busy is never asserted. Each
// result appears on out_result with a one-cycle out_valid strobe, its latency
// set by the 32-stage square-root pipeline feeding the elevation cordic chain.
// The receiver cannot stall the block: every strobed result must be captured in
// that cycle.
module vector_to_azimuth_elevation_unit import vae_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_item,
  output logic        out_valid,
  output out_result_t out_result
);

  localparam int AZ_DLY  = SQ_STAGES + 1;
  localparam int ESIDE_W = 3;
  localparam int SSIDE_W = ESIDE_W + DIFF_W;
  localparam int VEC_PAD = CORDIC_W - DIFF_W - VEC_SHIFT;
  localparam int EX_PAD  = CORDIC_W - SQ_OUT_W - EL_X_SHIFT;

  logic in_acc;

  // stage 1: difference vector
  logic                     s1_v_r;
  logic signed [DIFF_W-1:0] s1_dx_r;
  logic signed [DIFF_W-1:0] s1_dy_r;
  logic signed [DIFF_W-1:0] s1_dz_r;
  logic signed [DIFF_W-1:0] dx_nxt;
  logic signed [DIFF_W-1:0] dy_nxt;
  logic signed [DIFF_W-1:0] dz_nxt;

  assign busy   = 1'b0;
  assign in_acc = start & ~busy;

  assign dx_nxt = {in_item.target_x[COORD_W-1], in_item.target_x}
                - {in_item.source_x[COORD_W-1], in_item.source_x};
  assign dy_nxt = {in_item.target_y[COORD_W-1], in_item.target_y}
                - {in_item.source_y[COORD_W-1], in_item.source_y};
  assign dz_nxt = {in_item.target_z[COORD_W-1], in_item.target_z}
                - {in_item.source_z[COORD_W-1], in_item.source_z};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_dx_r <= dx_nxt;
      s1_dy_r <= dy_nxt;
      s1_dz_r <= dz_nxt;
    end
  end

  // azimuth cordic setup, left half plane folded by 180 degrees
  logic                       s1_zero;
  logic signed [CORDIC_W-1:0] ax_ext;
  logic signed [CORDIC_W-1:0] ay_ext;
  logic signed [CORDIC_W-1:0] az_x0;
  logic signed [CORDIC_W-1:0] az_y0;
  logic signed [ANG_W-1:0]    az_z0;

  assign s1_zero = (s1_dx_r == '0) && (s1_dy_r == '0);
  assign ax_ext  = {{VEC_PAD{s1_dx_r[DIFF_W-1]}}, s1_dx_r, {VEC_SHIFT{1'b0}}};
  assign ay_ext  = {{VEC_PAD{s1_dy_r[DIFF_W-1]}}, s1_dy_r, {VEC_SHIFT{1'b0}}};

  always_comb begin
    if (s1_dx_r[DIFF_W-1]) begin
      az_x0 = -ax_ext;
      az_y0 = -ay_ext;
      az_z0 = s1_dy_r[DIFF_W-1] ? -DEG180_Q16 : DEG180_Q16;
    end else begin
      az_x0 = ax_ext;
      az_y0 = ay_ext;
      az_z0 = '0;
    end
  end

  logic                    azc_valid;
  logic signed [ANG_W-1:0] azc_z;
  logic                    azc_zero;

  vae_cordic #(
    .STAGES (CORDIC_STAGES),
    .SIDE_W (1)
  ) u_az_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_v_r),
    .in_x      (az_x0),
    .in_y      (az_y0),
    .in_z      (az_z0),
    .in_side   (s1_zero),
    .out_valid (azc_valid),
    .out_z     (azc_z),
    .out_side  (azc_zero)
  );

  // azimuth rounding and wrap, then delay to meet the elevation path
  logic signed [ANG_W-1:0] az_sum;
  logic signed [RND_W-1:0] az_rnd;
  logic signed [RND_W-1:0] az_wrap;
  logic signed [AZ_W-1:0]  az_nxt;
  logic signed [AZ_W-1:0]  az_r;
  logic signed [AZ_W-1:0]  az_dly_r [AZ_DLY];

  assign az_sum = azc_z + ROUND_HALF;
  assign az_rnd = az_sum[ANG_W-1:RND_SHIFT];

  always_comb begin
    priority if (az_rnd > AZ_LIMIT) begin
      az_wrap = az_rnd - AZ_SPAN;
    end else if (az_rnd < -AZ_LIMIT) begin
      az_wrap = az_rnd + AZ_SPAN;
    end else begin
      az_wrap = az_rnd;
    end
    az_nxt = azc_zero ? '0 : az_wrap[AZ_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (azc_valid) begin
      az_r <= az_nxt;
    end
  end

  always_ff @(posedge clk) begin
    az_dly_r[0] <= az_r;
    for (int j = 1; j < AZ_DLY; j++) begin
      az_dly_r[j] <= az_dly_r[j-1];
    end
  end

  // stage 2: squares
  logic                     s2_v_r;
  logic signed [SQR_W-1:0]  s2_sqx_r;
  logic signed [SQR_W-1:0]  s2_sqy_r;
  logic signed [DIFF_W-1:0] s2_dz_r;
  logic                     s2_zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_sqx_r  <= SQR_W'(s1_dx_r) * SQR_W'(s1_dx_r);
    s2_sqy_r  <= SQR_W'(s1_dy_r) * SQR_W'(s1_dy_r);
    s2_dz_r   <= s1_dz_r;
    s2_zero_r <= s1_zero;
  end

  // stage 3: horizontal length squared
  logic                     s3_v_r;
  logic [SQR_W-1:0]         s3_h2_r;
  logic [SSIDE_W-1:0]       s3_side_r;
  logic                     dz_pos;

  assign dz_pos = !s2_dz_r[DIFF_W-1] && (s2_dz_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_h2_r   <= $unsigned(s2_sqx_r) + $unsigned(s2_sqy_r);
    s3_side_r <= {s2_zero_r, dz_pos, s2_dz_r[DIFF_W-1], s2_dz_r};
  end

  logic                sq_valid;
  logic [SQ_OUT_W-1:0] sq_root;
  logic [SSIDE_W-1:0]  sq_side;

  vae_sqrt #(
    .SIDE_W (SSIDE_W)
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s3_v_r),
    .in_n      ({s3_h2_r, {FRAC_PAD{1'b0}}}),
    .in_side   (s3_side_r),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  // elevation cordic setup
  logic signed [DIFF_W-1:0]   sq_dz;
  logic signed [CORDIC_W-1:0] el_x0;
  logic signed [CORDIC_W-1:0] el_y0;

  assign sq_dz = sq_side[DIFF_W-1:0];
  assign el_x0 = {{EX_PAD{1'b0}}, sq_root, {EL_X_SHIFT{1'b0}}};
  assign el_y0 = {{VEC_PAD{sq_dz[DIFF_W-1]}}, sq_dz, {VEC_SHIFT{1'b0}}};

  logic                    elc_valid;
  logic signed [ANG_W-1:0] elc_z;
  logic [ESIDE_W-1:0]      elc_side;

  vae_cordic #(
    .STAGES (CORDIC_STAGES),
    .SIDE_W (ESIDE_W)
  ) u_el_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sq_valid),
    .in_x      (el_x0),
    .in_y      (el_y0),
    .in_z      ('0),
    .in_side   (sq_side[SSIDE_W-1:DIFF_W]),
    .out_valid (elc_valid),
    .out_z     (elc_z),
    .out_side  (elc_side)
  );

  // final stage: elevation rounding, saturation and vertical special case
  logic signed [ANG_W-1:0] el_sum;
  logic signed [RND_W-1:0] el_rnd;
  logic signed [RND_W-1:0] el_sat;
  logic                    fin_zero;
  logic                    fin_dzp;
  logic                    fin_dzn;
  out_result_t             res_nxt;
  out_result_t             res_r;
  logic                    out_valid_r;

  assign el_sum = elc_z + ROUND_HALF;
  assign el_rnd = el_sum[ANG_W-1:RND_SHIFT];
  assign {fin_zero, fin_dzp, fin_dzn} = elc_side;

  always_comb begin
    priority if (fin_zero) begin
      el_sat = fin_dzp ? EL_LIMIT : (fin_dzn ? -EL_LIMIT : '0);
    end else if (el_rnd > EL_LIMIT) begin
      el_sat = EL_LIMIT;
    end else if (el_rnd < -EL_LIMIT) begin
      el_sat = -EL_LIMIT;
    end else begin
      el_sat = el_rnd;
    end
    res_nxt.azimuth   = az_dly_r[AZ_DLY-1];
    res_nxt.elevation = el_sat[EL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= elc_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (elc_valid) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = res_r;

endmodule

>>> sim/testbench.sv
// testbench: checks vector_to_azimuth_elevation_unit against its own model of
// the cordic azimuth/elevation math; depends on vae_pkg and the unit rtl
`timescale 1ns / 1ps

module testbench;
  import vae_pkg::*;

  localparam int     STAGES        = CORDIC_STAGES_DEF;
  localparam int     LATENCY       = STAGES + 36;
  localparam int     QUIET_LIMIT   = 1000;
  localparam int     RANDOM_POINTS = 1800;
  localparam longint HALF_TURN_Q16 = 11796480;
  localparam longint AZ_MAX        = 46080;
  localparam longint AZ_WRAP       = 92160;
  localparam longint EL_MAX        = 22784;
  localparam longint C_MAX         = 8388607;
  localparam longint C_MIN         = -8388608;
  localparam longint ATAN_Q16 [24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  typedef struct {
    in_item_t point;
    int       gap;
  } pending_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_item_t    in_item = '0;
  logic        out_valid;
  out_result_t out_result;

  pending_t    points_to_send[$];
  out_result_t angles_due[$];
  pending_t    next_point;
  out_result_t want;
  logic        took_item = 1'b0;
  logic        gap_loaded = 1'b0;
  int          idle_left = 0;
  int          quiet_cycles = 0;
  int          err_count = 0;
  int          calm_left = 0;
  logic        calm = 1'b0;

  vector_to_azimuth_elevation_unit #(
    .CORDIC_STAGES(STAGES)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_result(out_result)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint cordic_angle(longint x, longint y, longint z);
    longint xs;
    longint ys;
    for (int i = 0; i < STAGES && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ATAN_Q16[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ATAN_Q16[i];
      end
    end
    return z;
  endfunction

  function automatic out_result_t predict_angles(in_item_t p);
    longint dx;
    longint dy;
    longint dz;
    longint x;
    longint y;
    longint z0;
    longint az;
    longint el;
    longint unsigned rem;
    longint unsigned root;
    longint unsigned bitv;
    out_result_t r;
    dx = longint'(p.target_x) - longint'(p.source_x);
    dy = longint'(p.target_y) - longint'(p.source_y);
    dz = longint'(p.target_z) - longint'(p.source_z);
    if (dx == 0 && dy == 0) begin
      az = 0;
      el = (dz > 0) ? EL_MAX : ((dz < 0) ? -EL_MAX : 0);
    end else begin
      x = dx <<< 24;
      y = dy <<< 24;
      z0 = 0;
      if (dx < 0) begin
        x = -x;
        y = -y;
        z0 = (dy >= 0) ? HALF_TURN_Q16 : -HALF_TURN_Q16;
      end
      az = (cordic_angle(x, y, z0) + 128) >>> 8;
      if (az > AZ_MAX) az = az - AZ_WRAP;
      else if (az < -AZ_MAX) az = az + AZ_WRAP;
      // horizontal length with 7 fraction bits, bitwise integer square root
      rem = longint'(dx * dx + dy * dy) << 14;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > rem) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (rem >= root + bitv) begin
          rem = rem - (root + bitv);
          root = (root >> 1) + bitv;
        end else begin
          root = root >> 1;
        end
        bitv = bitv >> 2;
      end
      el = (cordic_angle(longint'(root) <<< 17, (dz * 128) <<< 17, 0) + 128) >>> 8;
      if (el > EL_MAX) el = EL_MAX;
      else if (el < -EL_MAX) el = -EL_MAX;
    end
    r.azimuth = az[AZ_W-1:0];
    r.elevation = el[EL_W-1:0];
    return r;
  endfunction

  function automatic longint coord_any();
    logic signed [COORD_W-1:0] v;
    v = COORD_W'($urandom);
    return longint'(v);
  endfunction

  function automatic longint coord_edge();
    case ($urandom_range(0, 4))
      0: return C_MIN;
      1: return C_MAX;
      2: return 0;
      3: return -1;
      default: return coord_any();
    endcase
  endfunction

  function automatic longint offset_within(int w);
    return longint'($urandom_range(0, 2 * w)) - w;
  endfunction

  task automatic queue_move(input longint sx, input longint sy, input longint sz,
                            input longint tx, input longint ty, input longint tz);
    pending_t e;
    e.point.source_x = sx[COORD_W-1:0];
    e.point.source_y = sy[COORD_W-1:0];
    e.point.source_z = sz[COORD_W-1:0];
    e.point.target_x = tx[COORD_W-1:0];
    e.point.target_y = ty[COORD_W-1:0];
    e.point.target_z = tz[COORD_W-1:0];
    // stretches of back-to-back transactions between stretches of random gaps
    if (calm_left == 0) begin
      calm = ($urandom_range(0, 3) == 0);
      calm_left = $urandom_range(5, 60);
    end
    calm_left--;
    e.gap = calm ? 0 : $urandom_range(0, 10);
    points_to_send.push_back(e);
  endtask

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || took_item) begin
      if (!gap_loaded && points_to_send.size() != 0) begin
        idle_left = points_to_send[0].gap;
        gap_loaded = 1'b1;
      end
      if (gap_loaded && idle_left == 0) begin
        next_point = points_to_send.pop_front();
        in_item <= next_point.point;
        start <= 1'b1;
        gap_loaded = 1'b0;
      end else begin
        if (gap_loaded) idle_left--;
        start <= 1'b0;
      end
    end
  end

  // monitor, checker and watchdog
  always @(posedge clk) begin
    if (!rst_n) begin
      took_item <= 1'b0;
    end else begin
      took_item <= start && !busy;
      if (start && !busy) angles_due.push_back(predict_angles(in_item));
      if (out_valid) begin
        if (angles_due.size() == 0) begin
          err_count++;
          $display("%0t: result with no transaction pending, expected none, got az %0d el %0d",
                   $time, out_result.azimuth, out_result.elevation);
        end else begin
          want = angles_due.pop_front();
          if (out_result.azimuth !== want.azimuth) begin
            err_count++;
            $display("%0t: azimuth mismatch, expected %0d, got %0d",
                     $time, want.azimuth, out_result.azimuth);
          end
          if (out_result.elevation !== want.elevation) begin
            err_count++;
            $display("%0t: elevation mismatch, expected %0d, got %0d",
                     $time, want.elevation, out_result.elevation);
          end
        end
      end
      if ((start && !busy) || out_valid) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
        $display("testbench: errors");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    longint sx;
    longint sy;
    longint sz;
    longint tx;
    longint ty;
    longint tz;
    int k;

    // directed
    queue_move(0, 0, 0, 0, 0, 0);
    queue_move(0, 0, 0, 0, 0, 5);
    queue_move(0, 0, 0, 0, 0, -5);
    queue_move(0, 0, C_MAX, 0, 0, C_MIN);
    queue_move(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN);
    queue_move(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX);
    queue_move(0, 0, 0, 100, 0, 0);
    queue_move(0, 0, 0, -100, 0, 0);
    queue_move(0, 0, 0, -1000, 1, 0);
    queue_move(0, 0, 0, -1000, -1, 0);
    queue_move(0, 0, 0, 0, C_MAX, 0);
    queue_move(0, 0, 0, 0, C_MIN, 0);
    queue_move(0, 0, 0, 1, 0, C_MAX);
    queue_move(0, 0, 0, 1, 0, C_MIN);
    queue_move(C_MAX, 0, 0, C_MIN, 0, 0);
    queue_move(C_MIN, 0, 0, C_MAX, 0, 0);
    queue_move(0, C_MIN, 0, 0, C_MAX, C_MAX);
    queue_move(0, 0, 0, 7, 7, 0);
    queue_move(0, 0, 0, 3, 4, 5);
    queue_move(1, 0, 0, 0, 0, 0);
    queue_move(0, 0, 0, 1, 1, 1);
    queue_move(C_MAX, C_MIN, 123, C_MAX, C_MIN, 123);
    queue_move(C_MIN, C_MAX, 0, C_MIN, C_MAX, C_MAX);
    queue_move(-5, -5, -5, -6, 4, -5);

    // random
    for (int n = 0; n < RANDOM_POINTS; n++) begin
      sx = coord_any();
      sy = coord_any();
      sz = coord_any();
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          tx = coord_any();
          ty = coord_any();
          tz = coord_any();
        end
        4, 5: begin
          tx = sx + offset_within(64);
          ty = sy + offset_within(64);
          tz = sz + offset_within(64);
        end
        6: begin
          tx = sx;
          ty = sy;
          tz = sz + offset_within(1 << $urandom_range(0, 23));
        end
        7: begin
          if ($urandom_range(0, 1) == 0) begin
            tx = sx + offset_within($urandom_range(0, 2));
            ty = coord_any();
          end else begin
            tx = coord_any();
            ty = sy + offset_within($urandom_range(0, 2));
          end
          tz = sz + offset_within(1 << $urandom_range(0, 23));
        end
        8: begin
          sx = coord_edge();
          sy = coord_edge();
          sz = coord_edge();
          tx = coord_edge();
          ty = coord_edge();
          tz = coord_edge();
        end
        default: begin
          k = $urandom_range(0, 23);
          tx = sx + offset_within(1 << k);
          ty = sy + offset_within(1 << k);
          tz = sz + offset_within(1 << $urandom_range(0, 23));
        end
      endcase
      queue_move(sx, sy, sz, tx, ty, tz);
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (points_to_send.size() != 0 || start) @(posedge clk);
    while (angles_due.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);

    if (err_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
